// ===== rtl/core/e2lc_pkg.sv =====
package e2lc_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_DAY,
        S_DIV_HOUR,
        S_DIV_MIN,
        S_WK_ADD,
        S_WK_MOD,
        S_YEAR,
        S_MONTH,
        S_DST,
        S_ADD_DST
    } seq_state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic {
        REG_ZONE_OFFSET = 1'b0,
        REG_SUMMER_EN   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [16:0] zone_offset;
        logic        summer_en;
    } cfg_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } cal_t;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
    localparam logic [31:0] EPOCH_WEEKDAY = 32'd4;
    localparam logic [11:0] BASE_YEAR     = 12'd1970;
    localparam logic [11:0] CENTURY_NO_LEAP = 12'd2100;

    localparam logic [4:0] DAY_DIV_LAST  = 5'd31;
    localparam logic [4:0] HOUR_DIV_LAST = 5'd4;
    localparam logic [4:0] MIN_DIV_LAST  = 5'd5;
    localparam logic [4:0] WK_DIV_LAST   = 5'd13;

    localparam logic [25:0] TM_SCALE = 26'd625;

    // years reachable from 32-bit seconds lie in 1970..2106
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != CENTURY_NO_LEAP);
    endfunction

    function automatic logic [8:0] year_len(input logic [11:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/e2lc_alu.sv =====
module e2lc_alu (
    input  e2lc_pkg::alu_op_t op,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic [31:0]       res,
    output logic              ge
);
    import e2lc_pkg::*;

    logic        sub;
    logic [32:0] sum;

    assign sub = (op == ALU_SUB);
    assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {32'd0, sub};
    assign res = sum[31:0];
    assign ge  = sub & sum[32];

endmodule

// ===== rtl/core/e2lc_dst_rule.sv =====
module e2lc_dst_rule (
    input  e2lc_pkg::cal_t cal,
    output logic           summer
);
    import e2lc_pkg::*;

    logic past_last_sunday;

    assign past_last_sunday = ((cal.weekday == 3'd0) && (cal.hour != 5'd0))
        || ((cal.weekday != 3'd0) && ({1'b0, cal.day} > ({3'd0, cal.weekday} + 6'd24)));

    always_comb
    begin
        priority if (cal.month < 4'd3 || cal.month > 4'd10)
        begin
            summer = 1'b0;
        end
        else if (cal.month > 4'd3 && cal.month < 4'd10)
        begin
            summer = 1'b1;
        end
        else if (cal.month == 4'd3)
        begin
            summer = (cal.day > 5'd24) && past_last_sunday;
        end
        else if (cal.day < 5'd25)
        begin
            summer = 1'b1;
        end
        else
        begin
            summer = !past_last_sunday;
        end
    end

endmodule

// ===== rtl/core/e2lc_seq.sv =====
module e2lc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      epoch_seconds,
    input  e2lc_pkg::cfg_t   cfg,
    output logic             busy,
    output logic             fin,
    output e2lc_pkg::cal_t   cal,
    output logic             summer
);
    import e2lc_pkg::*;

    seq_state_t  state_reg;
    seq_state_t  state_next;

    logic [31:0] secs_reg;
    logic [31:0] t_reg;
    logic [16:0] rem_reg;
    logic [15:0] days_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  cnt_reg;
    logic        pass_reg;
    logic        dst_reg;

    alu_op_t     alu_op;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic [31:0] alu_res;
    logic        alu_ge;

    logic [17:0] div_in;
    logic        cnt_last;
    logic        go_local;
    logic        rule_hit;

    e2lc_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    e2lc_dst_rule u_rule (
        .cal    (cal),
        .summer (rule_hit)
    );

    assign div_in   = {rem_reg, t_reg[cnt_reg]};
    assign cnt_last = (cnt_reg == 5'd0);
    assign go_local = !pass_reg && ((cfg.zone_offset != 17'd0) || cfg.summer_en);

    assign cal.year    = year_reg;
    assign cal.month   = month_reg + 4'd1;
    assign cal.day     = days_reg[4:0] + 5'd1;
    assign cal.hour    = hour_reg;
    assign cal.minute  = minute_reg;
    assign cal.second  = second_reg;
    assign cal.weekday = rem_reg[2:0];

    assign busy   = (state_reg != S_IDLE);
    assign fin    = (state_reg == S_MONTH) && !alu_ge && !go_local;
    assign summer = dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (start) state_next = S_DIV_DAY;
            S_DIV_DAY:  if (cnt_last) state_next = S_DIV_HOUR;
            S_DIV_HOUR: if (cnt_last) state_next = S_DIV_MIN;
            S_DIV_MIN:  if (cnt_last) state_next = S_WK_ADD;
            S_WK_ADD:   state_next = S_WK_MOD;
            S_WK_MOD:   if (cnt_last) state_next = S_YEAR;
            S_YEAR:     if (!alu_ge) state_next = S_MONTH;
            S_MONTH:    if (!alu_ge) state_next = go_local ? S_DST : S_IDLE;
            S_DST:      state_next = S_ADD_DST;
            S_ADD_DST:  state_next = S_DIV_DAY;
            default:    state_next = S_IDLE;
        endcase
    end

    // operand selection for the shared adder
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_DIV_DAY:
            begin
                alu_a = {14'd0, div_in};
                alu_b = SECS_PER_DAY;
            end
            S_DIV_HOUR:
            begin
                alu_a = {15'd0, rem_reg};
                alu_b = SECS_PER_HOUR << cnt_reg;
            end
            S_DIV_MIN:
            begin
                alu_a = {15'd0, rem_reg};
                alu_b = SECS_PER_MIN << cnt_reg;
            end
            S_WK_ADD:
            begin
                alu_op = ALU_ADD;
                alu_a  = {16'd0, days_reg};
                alu_b  = EPOCH_WEEKDAY;
            end
            S_WK_MOD:
            begin
                alu_a = {15'd0, rem_reg};
                alu_b = DAYS_PER_WEEK << cnt_reg;
            end
            S_YEAR:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = {23'd0, year_len(year_reg)};
            end
            S_MONTH:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = {27'd0, month_len(month_reg, is_leap(year_reg))};
            end
            S_DST:
            begin
                alu_op = ALU_ADD;
                alu_a  = secs_reg;
                alu_b  = {{15{cfg.zone_offset[16]}}, cfg.zone_offset};
            end
            S_ADD_DST:
            begin
                alu_op = ALU_ADD;
                alu_a  = t_reg;
                alu_b  = SECS_PER_HOUR;
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    secs_reg <= epoch_seconds;
                    t_reg    <= epoch_seconds;
                    rem_reg  <= '0;
                    days_reg <= '0;
                    cnt_reg  <= DAY_DIV_LAST;
                    pass_reg <= 1'b0;
                    dst_reg  <= 1'b0;
                end
            end
            S_DIV_DAY:
            begin
                rem_reg  <= alu_ge ? alu_res[16:0] : div_in[16:0];
                days_reg <= {days_reg[14:0], alu_ge};
                cnt_reg  <= cnt_last ? HOUR_DIV_LAST : cnt_reg - 5'd1;
            end
            S_DIV_HOUR:
            begin
                rem_reg  <= alu_ge ? alu_res[16:0] : rem_reg;
                hour_reg <= {hour_reg[3:0], alu_ge};
                cnt_reg  <= cnt_last ? MIN_DIV_LAST : cnt_reg - 5'd1;
            end
            S_DIV_MIN:
            begin
                rem_reg    <= alu_ge ? alu_res[16:0] : rem_reg;
                minute_reg <= {minute_reg[4:0], alu_ge};
                cnt_reg    <= cnt_reg - 5'd1;
            end
            S_WK_ADD:
            begin
                second_reg <= rem_reg[5:0];
                rem_reg    <= alu_res[16:0];
                cnt_reg    <= WK_DIV_LAST;
            end
            S_WK_MOD:
            begin
                rem_reg  <= alu_ge ? alu_res[16:0] : rem_reg;
                cnt_reg  <= cnt_reg - 5'd1;
                year_reg <= BASE_YEAR;
            end
            S_YEAR:
            begin
                if (alu_ge)
                begin
                    days_reg <= alu_res[15:0];
                    year_reg <= year_reg + 12'd1;
                end
                month_reg <= '0;
            end
            S_MONTH:
            begin
                if (alu_ge)
                begin
                    days_reg  <= alu_res[15:0];
                    month_reg <= month_reg + 4'd1;
                end
            end
            S_DST:
            begin
                dst_reg <= cfg.summer_en & rule_hit;
                t_reg   <= alu_res;
            end
            S_ADD_DST:
            begin
                if (dst_reg)
                begin
                    t_reg <= alu_res;
                end
                rem_reg  <= '0;
                days_reg <= '0;
                cnt_reg  <= DAY_DIV_LAST;
                pass_reg <= 1'b1;
            end
            default:
            begin
                cnt_reg <= DAY_DIV_LAST;
            end
        endcase
    end

endmodule

// ===== rtl/core/epoch_to_local_calendar_time.sv =====
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------------
// input     | start, busy             | epoch_seconds, second_fraction
// config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
// result    | done                    | year, month, day, hour, minute, second,
//           |                         | weekday, tenth_millis, summer_time
//
// an item goes from start to its result beat through one shared 32-bit adder; a second pass
// runs when an offset or summer time is set
// done pulses in the first cycle with busy low; results stay on the ports until the next beat
// rst_n clears the sequencer and both registers at once; results are never stalled
module epoch_to_local_calendar_time (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    input  logic [15:0] second_fraction,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday,
    output logic [13:0] tenth_millis,
    output logic        summer_time
);
    import e2lc_pkg::*;

    cfg_t        cfg_reg;
    logic        done_reg;
    logic [15:0] frac_reg;
    cal_t        cal_out_reg;
    logic [13:0] tm_reg;
    logic        summer_reg;

    logic        seq_busy;
    logic        seq_fin;
    cal_t        seq_cal;
    logic        seq_summer;
    logic        accept;
    logic [25:0] frac_prod;

    assign accept    = start && !seq_busy;
    assign frac_prod = {10'd0, frac_reg} * TM_SCALE;

    e2lc_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .epoch_seconds (epoch_seconds),
        .cfg           (cfg_reg),
        .busy          (seq_busy),
        .fin           (seq_fin),
        .cal           (seq_cal),
        .summer        (seq_summer)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= seq_fin;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ZONE_OFFSET: cfg_reg.zone_offset <= cfg_data;
                    REG_SUMMER_EN:   cfg_reg.summer_en   <= cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frac_reg <= second_fraction;
        end
        if (seq_fin)
        begin
            cal_out_reg <= seq_cal;
            tm_reg      <= frac_prod[25:12];
            summer_reg  <= seq_summer;
        end
    end

    assign busy         = seq_busy;
    assign cfg_ready    = !seq_busy;
    assign done         = done_reg;
    assign year         = cal_out_reg.year;
    assign month        = cal_out_reg.month;
    assign day          = cal_out_reg.day;
    assign hour         = cal_out_reg.hour;
    assign minute       = cal_out_reg.minute;
    assign second       = cal_out_reg.second;
    assign weekday      = cal_out_reg.weekday;
    assign tenth_millis = tm_reg;
    assign summer_time  = summer_reg;

endmodule

// ===== rtl/core/e2lc_checker.sv =====
module e2lc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] month,
    input logic [4:0] day,
    input logic [4:0] hour,
    input logic [5:0] minute,
    input logic [5:0] second,
    input logic [2:0] weekday
);

    // one beat per result
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result beat");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23
                  && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6))
        else $error("calendar field out of range");

endmodule

bind epoch_to_local_calendar_time e2lc_checker u_e2lc_checker (.*);
